FILE: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
package pfba_pkg;

  localparam int unsigned NUM_FRAMES_DEF  = 65536;
  localparam int unsigned FRAME_BYTES_DEF = 4096;
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned WORD_LG         = 5;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned CNT_W           = 17;
  localparam int unsigned TOT_W           = 17;
  localparam int unsigned ADDR_W          = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RECOUNT = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SETUP,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_READ,
    OP_EXEC,
    OP_WRAP,
    OP_FIN,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             go;
    logic             clr_last;
    logic             mod_last;
    logic             last_word;
    logic             hit;
    logic             start_zero;
    logic             out_busy;
  } dp_stat_t;

  function automatic logic [WORD_BITS-1:0] range_mask(input logic [WORD_LG-1:0] lo,
                                                       input logic [WORD_LG-1:0] hi);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    a = {WORD_BITS{1'b1}} << lo;
    b = {WORD_BITS{1'b1}} >> (5'd31 - hi);
    return a & b;
  endfunction

  function automatic logic [WORD_LG-1:0] low_index(input logic [WORD_BITS-1:0] v);
    logic [WORD_LG-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = WORD_LG'(i);
    end
    return idx;
  endfunction

  function automatic logic [WORD_LG:0] ones_count(input logic [WORD_BITS-1:0] v);
    logic [WORD_LG:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + {{WORD_LG{1'b0}}, v[i]};
    end
    return n;
  endfunction

endpackage

FILE: rtl/pfba_cmd_if.sv
`timescale 1ns / 1ps
interface pfba_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] address;
  logic [31:0] length;

  modport source(output valid, output command, output address, output length, input ready);
  modport sink(input valid, input command, input address, input length, output ready);
endinterface

FILE: rtl/pfba_rsp_if.sv
`timescale 1ns / 1ps
interface pfba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_address;
  logic        granted;
  logic [16:0] free_frames;
  logic [16:0] used_frames;
  logic        ready_flag;

  modport source(output valid, output frame_address, output granted, output free_frames,
                 output used_frames, output ready_flag, input ready);
  modport sink(input valid, input frame_address, input granted, input free_frames,
               input used_frames, input ready_flag, output ready);
endinterface

FILE: rtl/page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// bitmap page frame allocator, next-fit search
// in_ch carries one command (allocate, free, reserve, release, recount) per
// transfer; out_ch returns one result transfer per command with the frame
// address, grant flag, free and used counts and the ready flag.
// cfg_we/cfg_wdata set the managed frame total; write only while idle.
// the used bitmap sits in a 32-bit-wide memory with one port each way.
// after reset a clearing pass marks every frame used, one word per cycle,
// over every bitmap word before the first command is taken.
// a command that changes nothing (refused allocate, ignored free, empty range,
// unknown) goes straight to the result; free reads and writes one bitmap word;
// reserve and release read and write each bitmap word covered; recount reads
// each word (none with a zero total) and sums the free bits; allocate takes
// the search start modulo the total bit by bit, then scans words, wrapping at most once.
// one command is in flight at a time; the next is taken once the result
// register is empty, so a stalled receiver holds off new commands.
module page_frame_bitmap_allocator #(
  parameter int unsigned NUM_FRAMES  = pfba_pkg::NUM_FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = pfba_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pfba_pkg::TOT_W-1:0] cfg_wdata,
  pfba_cmd_if.sink                   in_ch,
  pfba_rsp_if.source                 out_ch
);
  import pfba_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .op       (op)
  );

  pfba_dp #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .command       (in_ch.command),
    .address       (in_ch.address),
    .length        (in_ch.length),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .frame_address (out_ch.frame_address),
    .granted       (out_ch.granted),
    .free_frames   (out_ch.free_frames),
    .used_frames   (out_ch.used_frames),
    .ready_flag    (out_ch.ready_flag)
  );

endmodule

FILE: rtl/pfba_dp.sv
`timescale 1ns / 1ps
module pfba_dp #(
  parameter int unsigned NUM_FRAMES  = pfba_pkg::NUM_FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = pfba_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfba_pkg::dp_op_t           op,
  output pfba_pkg::dp_stat_t         stat,
  input  logic                       cfg_we,
  input  logic [pfba_pkg::TOT_W-1:0] cfg_wdata,
  input  logic [2:0]                 command,
  input  logic [31:0]                address,
  input  logic [31:0]                length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                frame_address,
  output logic                       granted,
  output logic [16:0]                free_frames,
  output logic [16:0]                used_frames,
  output logic                       ready_flag
);
  import pfba_pkg::*;

  localparam int unsigned FB_LG  = $clog2(FRAME_BYTES);
  localparam int unsigned ETW    = $clog2(NUM_FRAMES + 1);
  localparam int unsigned NWORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = $clog2(NWORDS);
  localparam int unsigned FXW    = AW + WORD_LG;
  localparam int unsigned MW     = $clog2(ETW);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata;

  logic [TOT_W-1:0] tot_reg;
  logic [ETW-1:0]   eff;
  logic [CMD_W-1:0] cmd_q;
  logic [31:0]      first_q;
  logic [ETW-1:0]   stop_q;
  logic [FXW-1:0]   lo_q;
  logic [FXW-1:0]   hi_q;
  logic [AW-1:0]    ptr;
  logic [ETW-1:0]   rem;
  logic [MW-1:0]    mstep;
  logic [ETW-1:0]   acc;
  logic [CNT_W-1:0] cnt;
  logic [ETW-1:0]   sstart;
  logic             rdy;
  logic             granted_q;
  logic [31:0]      addr_out_q;

  logic [31:0]          stop_sum;
  logic [31:0]          stop_frame;
  logic [ETW-1:0]       stop_clamp;
  logic [FXW-1:0]       setup_lo;
  logic [FXW-1:0]       setup_hi;
  logic [WORD_LG-1:0]   lo_w;
  logic [WORD_LG-1:0]   hi_w;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_LG-1:0]   pe;
  logic [FXW-1:0]       hit_frame;
  logic [ETW:0]         rem_sh;
  logic                 go;
  logic                 hit;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign eff = (32'(tot_reg) > NUM_FRAMES) ? ETW'(NUM_FRAMES) : ETW'(tot_reg);

  assign stop_sum   = address + length + 32'(FRAME_BYTES - 1);
  assign stop_frame = stop_sum >> FB_LG;
  assign stop_clamp = (stop_frame > 32'(eff)) ? eff : ETW'(stop_frame);

  always_comb begin
    setup_lo = '0;
    setup_hi = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        setup_lo = FXW'(rem);
        setup_hi = FXW'(eff - 1'b1);
      end
      CMD_FREE: begin
        setup_lo = FXW'(first_q);
        setup_hi = FXW'(first_q);
      end
      CMD_RESERVE, CMD_RELEASE: begin
        setup_lo = FXW'(first_q);
        setup_hi = FXW'(stop_q - 1'b1);
      end
      CMD_RECOUNT: begin
        setup_lo = '0;
        setup_hi = FXW'(eff - 1'b1);
      end
      default: begin
        setup_lo = '0;
        setup_hi = '0;
      end
    endcase
  end

  always_comb begin
    go = 1'b0;
    case (cmd_q)
      CMD_ALLOC:                go = rdy && (cnt != '0) && (eff != '0);
      CMD_FREE:                 go = rdy && (first_q < 32'(eff));
      CMD_RESERVE, CMD_RELEASE: go = first_q < 32'(stop_q);
      CMD_RECOUNT:              go = eff != '0;
      default:                  go = 1'b0;
    endcase
  end

  assign lo_w = (ptr == lo_q[FXW-1:WORD_LG]) ? lo_q[WORD_LG-1:0] : '0;
  assign hi_w = (ptr == hi_q[FXW-1:WORD_LG]) ? hi_q[WORD_LG-1:0] : '1;
  assign mask = range_mask(lo_w, hi_w);
  assign cand = ~rdata & mask;
  assign pe   = low_index(cand);
  assign hit_frame = {ptr, pe};
  assign hit  = (cmd_q == CMD_FREE) ? |(rdata & mask) : |cand;
  assign rem_sh = {rem, sstart[mstep]};

  assign stat.cmd        = cmd_q;
  assign stat.go         = go;
  assign stat.clr_last   = ptr == AW'(NWORDS - 1);
  assign stat.mod_last   = mstep == '0;
  assign stat.last_word  = ptr == hi_q[FXW-1:WORD_LG];
  assign stat.hit        = hit;
  assign stat.start_zero = rem == '0;
  assign stat.out_busy   = out_valid;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = '1;
    if (op == OP_CLEAR) begin
      wr_en = 1'b1;
    end else if (op == OP_EXEC) begin
      case (cmd_q)
        CMD_ALLOC: begin
          wr_en   = hit;
          wr_data = rdata | (WORD_BITS'(1) << pe);
        end
        CMD_FREE: begin
          wr_en   = hit;
          wr_data = rdata & ~mask;
        end
        CMD_RESERVE: begin
          wr_en   = 1'b1;
          wr_data = rdata | mask;
        end
        CMD_RELEASE: begin
          wr_en   = 1'b1;
          wr_data = rdata & ~mask;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (op == OP_READ) rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_reg   <= '0;
      ptr       <= '0;
      cnt       <= '0;
      sstart    <= '0;
      rdy       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) tot_reg <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (op)
        OP_CLEAR: ptr <= ptr + 1'b1;
        OP_LOAD: begin
          cmd_q     <= command;
          first_q   <= address >> FB_LG;
          stop_q    <= stop_clamp;
          granted_q <= 1'b0;
          acc       <= '0;
        end
        OP_SETUP: begin
          lo_q <= setup_lo;
          hi_q <= setup_hi;
          ptr  <= setup_lo[FXW-1:WORD_LG];
        end
        OP_MOD_INIT: begin
          rem   <= '0;
          mstep <= MW'(ETW - 1);
        end
        OP_MOD_STEP: begin
          rem   <= (rem_sh >= {1'b0, eff}) ? ETW'(rem_sh - {1'b0, eff}) : ETW'(rem_sh);
          mstep <= mstep - 1'b1;
        end
        OP_WRAP: begin
          lo_q <= '0;
          hi_q <= FXW'(rem - 1'b1);
          ptr  <= '0;
        end
        OP_EXEC: begin
          ptr <= ptr + 1'b1;
          case (cmd_q)
            CMD_ALLOC: begin
              if (hit) begin
                cnt        <= cnt - 1'b1;
                sstart     <= ETW'(hit_frame) + 1'b1;
                addr_out_q <= 32'(hit_frame) << FB_LG;
                granted_q  <= 1'b1;
              end
            end
            CMD_FREE: begin
              if (hit && cnt != COUNT_MAX) cnt <= cnt + 1'b1;
            end
            CMD_RECOUNT: acc <= acc + ETW'(ones_count(cand));
            default: ;
          endcase
        end
        OP_FIN: begin
          cnt <= (32'(acc) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(acc);
          rdy <= 1'b1;
        end
        OP_RESULT: begin
          out_valid     <= 1'b1;
          frame_address <= granted_q ? addr_out_q : '0;
          granted       <= granted_q;
          free_frames   <= cnt;
          used_frames   <= (rdy && tot_reg > cnt) ? tot_reg - cnt : '0;
          ready_flag    <= rdy;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pfba_ctrl.sv
`timescale 1ns / 1ps
module pfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfba_pkg::dp_stat_t stat,
  output pfba_pkg::dp_op_t   op
);
  import pfba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_MOD,
    S_ASETUP,
    S_READ,
    S_EXEC,
    S_WRAP,
    S_FIN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   phase;

  assign in_ready = (state == S_IDLE) && !stat.out_busy;

  always_comb begin
    op         = OP_NONE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op         = OP_LOAD;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (!stat.go) begin
          state_next = (stat.cmd == CMD_RECOUNT) ? S_FIN : S_RESULT;
        end else if (stat.cmd == CMD_ALLOC) begin
          op         = OP_MOD_INIT;
          state_next = S_MOD;
        end else begin
          op         = OP_SETUP;
          state_next = S_READ;
        end
      end
      S_MOD: begin
        op = OP_MOD_STEP;
        if (stat.mod_last) state_next = S_ASETUP;
      end
      S_ASETUP: begin
        op         = OP_SETUP;
        state_next = S_READ;
      end
      S_READ: begin
        op         = OP_READ;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        op = OP_EXEC;
        case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.hit) state_next = S_RESULT;
            else if (stat.last_word)
              state_next = (phase || stat.start_zero) ? S_RESULT : S_WRAP;
            else state_next = S_READ;
          end
          CMD_RESERVE, CMD_RELEASE: state_next = stat.last_word ? S_RESULT : S_READ;
          CMD_RECOUNT: state_next = stat.last_word ? S_FIN : S_READ;
          default: state_next = S_RESULT;
        endcase
      end
      S_WRAP: begin
        op         = OP_WRAP;
        state_next = S_READ;
      end
      S_FIN: begin
        op         = OP_FIN;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        op         = OP_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_LOAD) phase <= 1'b0;
      else if (op == OP_WRAP) phase <= 1'b1;
    end
  end

endmodule

FILE: test/page_frame_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
module page_frame_bitmap_allocator_tb;
  import pfba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd5;
  localparam int unsigned PAGE = 4096;
  localparam int unsigned MAP_SIZE = 65536;

  typedef struct packed {
    logic [31:0] frame_address;
    logic        granted;
    logic [16:0] free_frames;
    logic [16:0] used_frames;
    logic        ready_flag;
  } frame_result_t;

  typedef struct packed {
    logic [16:0]      total;
    logic [CMD_W-1:0] cmd;
    logic [31:0]      addr;
    logic [31:0]      len;
    logic             typed;
    frame_result_t    res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [TOT_W-1:0] cfg_wdata;

  pfba_cmd_if cmd_ch ();
  pfba_rsp_if rsp_ch ();

  page_frame_bitmap_allocator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(cmd_ch.sink),
    .out_ch(rsp_ch.source)
  );

  // allocator mirror
  bit          used_map [MAP_SIZE];
  int unsigned free_cnt;
  int unsigned next_fit;
  bit          alloc_ready;
  int unsigned total_reg;

  frame_result_t pending_results[$];
  int unsigned   granted_addrs[$];
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   grants_seen;
  bit            quiet;

  function automatic int unsigned managed_frames();
    return (total_reg > MAP_SIZE) ? MAP_SIZE : total_reg;
  endfunction

  function automatic void mark_frames(logic [31:0] addr, logic [31:0] len, bit val);
    logic [31:0] stop;
    int unsigned first;
    int unsigned last;
    first = addr / PAGE;
    stop = addr + len;
    stop = (stop + 32'(PAGE - 1)) & ~32'(PAGE - 1);
    last = stop / PAGE;
    if (last > managed_frames()) last = managed_frames();
    for (int unsigned f = first; f < last; f++) used_map[f] = val;
  endfunction

  function automatic frame_result_t apply_command(logic [CMD_W-1:0] cmd, logic [31:0] addr,
                                                  logic [31:0] len);
    frame_result_t r;
    int unsigned tot;
    int unsigned f;
    int unsigned n;
    r = '0;
    tot = managed_frames();
    case (cmd)
      CMD_ALLOC: begin
        if (alloc_ready && free_cnt != 0 && tot != 0) begin
          for (int unsigned i = 0; i < tot; i++) begin
            f = (longint'(next_fit) + i) % tot;
            if (!used_map[f]) begin
              used_map[f] = 1'b1;
              free_cnt--;
              next_fit = f + 1;
              r.frame_address = 32'(f * PAGE);
              r.granted = 1'b1;
              break;
            end
          end
        end
      end
      CMD_FREE: begin
        f = addr / PAGE;
        if (alloc_ready && f < tot && used_map[f]) begin
          used_map[f] = 1'b0;
          if (free_cnt < COUNT_MAX) free_cnt++;
        end
      end
      CMD_RESERVE: mark_frames(addr, len, 1'b1);
      CMD_RELEASE: mark_frames(addr, len, 1'b0);
      CMD_RECOUNT: begin
        n = 0;
        for (int unsigned i = 0; i < tot; i++) if (!used_map[i]) n++;
        free_cnt = (n > COUNT_MAX) ? COUNT_MAX : n;
        alloc_ready = 1'b1;
      end
      default: ;
    endcase
    r.free_frames = 17'(free_cnt);
    if (alloc_ready && total_reg > free_cnt) r.used_frames = 17'(total_reg - free_cnt);
    r.ready_flag = alloc_ready;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("page_frame_bitmap_allocator_tb: FAIL");
    $finish;
  end

  // result side
  always @(negedge clk) begin
    rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.frame_address, rsp_ch.granted, rsp_ch.free_frames,
              rsp_ch.used_frames, rsp_ch.ready_flag};
      results_seen++;
      if (got.granted) grants_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.frame_address !== want.frame_address) begin
          $error("frame_address expected %h actual %h", want.frame_address, got.frame_address);
          errors++;
        end
        if (got.granted !== want.granted) begin
          $error("granted expected %b actual %b", want.granted, got.granted);
          errors++;
        end
        if (got.free_frames !== want.free_frames) begin
          $error("free_frames expected %0d actual %0d", want.free_frames, got.free_frames);
          errors++;
        end
        if (got.used_frames !== want.used_frames) begin
          $error("used_frames expected %0d actual %0d", want.used_frames, got.used_frames);
          errors++;
        end
        if (got.ready_flag !== want.ready_flag) begin
          $error("ready_flag expected %b actual %b", want.ready_flag, got.ready_flag);
          errors++;
        end
      end
    end
  end

  task automatic issue(logic [CMD_W-1:0] cmd, logic [31:0] addr, logic [31:0] len,
                       bit typed, frame_result_t typed_res);
    frame_result_t r;
    while (!quiet && $urandom_range(0, 99) < 22) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.command = cmd;
    cmd_ch.address = addr;
    cmd_ch.length = len;
    do @(posedge clk); while (!cmd_ch.ready);
    r = apply_command(cmd, addr, len);
    if (r.granted) granted_addrs.push_back(r.frame_address);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic set_total(int unsigned value);
    cmd_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = TOT_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    total_reg = value;
  endtask

  task automatic random_phase(int unsigned value, int unsigned count);
    int unsigned r;
    int unsigned idx;
    logic [CMD_W-1:0] cmd;
    logic [31:0] addr;
    logic [31:0] len;
    set_total(value);
    granted_addrs.delete();
    issue(CMD_RELEASE, 0, 32'(managed_frames() * PAGE), 0, '0);
    issue(CMD_RECOUNT, 0, 0, 0, '0);
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      addr = 32'($urandom_range(0, managed_frames() + 2) * PAGE + $urandom_range(0, PAGE - 1));
      len = $urandom_range(0, 8 * PAGE);
      if ($urandom_range(0, 9) == 0) begin
        addr = $urandom;
        len = $urandom;
      end
      if (r < 40) cmd = CMD_ALLOC;
      else if (r < 65) begin
        cmd = CMD_FREE;
        if (granted_addrs.size() != 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, granted_addrs.size() - 1);
          addr = granted_addrs[idx] + $urandom_range(0, PAGE - 1);
          granted_addrs.delete(idx);
        end
      end
      else if (r < 75) cmd = CMD_RESERVE;
      else if (r < 85) cmd = CMD_RELEASE;
      else if (r < 90) cmd = CMD_RECOUNT;
      else if (r < 95) cmd = CMD_UNUSED + 3'($urandom_range(0, 2));
      else begin
        cmd = 3'($urandom_range(0, 7));
        addr = $urandom;
        len = $urandom;
      end
      issue(cmd, addr, len, 0, '0);
    end
  endtask

  stim_row_t directed [] = '{
    '{17'd0, CMD_ALLOC, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd0, 17'd0, 1'b0}},
    '{17'd0, CMD_FREE, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd0, 17'd0, 1'b0}},
    '{17'd0, CMD_RECOUNT, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd0, 17'd0, 1'b1}},
    '{17'd0, CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
      '{32'h0, 1'b0, 17'd0, 17'd0, 1'b1}},
    '{17'd0, CMD_ALLOC, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd0, 17'd0, 1'b1}},
    '{17'd64, CMD_RELEASE, 32'h0, 32'h40000, 1'b1, '{32'h0, 1'b0, 17'd0, 17'd64, 1'b1}},
    '{17'd64, CMD_RECOUNT, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd64, 17'd0, 1'b1}},
    '{17'd64, CMD_ALLOC, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b1, 17'd63, 17'd1, 1'b1}},
    '{17'd64, CMD_ALLOC, 32'h0, 32'h0, 1'b1, '{32'h1000, 1'b1, 17'd62, 17'd2, 1'b1}},
    '{17'd64, CMD_FREE, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd63, 17'd1, 1'b1}},
    '{17'd64, CMD_FREE, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 17'd63, 17'd1, 1'b1}},
    '{17'd64, CMD_FREE, 32'h40000, 32'h0, 1'b0, '0},
    '{17'd64, CMD_FREE, 32'hFFFFFFFF, 32'h0, 1'b0, '0},
    '{17'd64, CMD_RESERVE, 32'hFFFFF000, 32'h2000, 1'b0, '0},
    '{17'd64, CMD_RESERVE, 32'h3F000, 32'h0, 1'b0, '0},
    '{17'd64, CMD_RESERVE, 32'h0, 32'hFFFFFFFF, 1'b0, '0},
    '{17'd64, CMD_RESERVE, 32'h1000, 32'h3E001, 1'b0, '0},
    '{17'd64, CMD_RECOUNT, 32'h0, 32'h0, 1'b0, '0},
    '{17'd64, CMD_ALLOC, 32'h0, 32'h0, 1'b0, '0},
    '{17'd64, CMD_RELEASE, 32'h0, 32'h40000, 1'b0, '0},
    '{17'd64, CMD_RECOUNT, 32'h0, 32'h0, 1'b0, '0},
    '{17'd10, 3'd7, 32'h0, 32'h0, 1'b0, '0},
    '{17'h1FFFF, CMD_RECOUNT, 32'h0, 32'h0, 1'b0, '0},
    '{17'h1FFFF, CMD_ALLOC, 32'h0, 32'h0, 1'b0, '0},
    '{17'd65536, 3'd6, 32'h0, 32'h0, 1'b0, '0}
  };

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_ALLOC;
    cmd_ch.address = '0;
    cmd_ch.length = '0;
    rsp_ch.ready = 1'b0;
    quiet = 1'b0;
    errors = 0;
    results_seen = 0;
    grants_seen = 0;
    for (int i = 0; i < MAP_SIZE; i++) used_map[i] = 1'b1;
    free_cnt = 0;
    next_fit = 0;
    alloc_ready = 1'b0;
    total_reg = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_total(0);
    foreach (directed[i]) begin
      if (directed[i].total != total_reg) set_total(directed[i].total);
      issue(directed[i].cmd, directed[i].addr, directed[i].len, directed[i].typed,
            directed[i].res);
    end

    random_phase(64, 170);
    random_phase(33, 150);
    random_phase(1, 60);
    quiet = 1'b1;
    random_phase(256, 180);
    quiet = 1'b0;
    random_phase(100, 170);
    random_phase(511, 150);
    random_phase(1024, 150);
    random_phase(65536, 12);
    random_phase(17'h1FFFF, 8);

    cmd_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
    $display("covered %0d results (%0d grants) over totals 0 to 0x1FFFF, %0d mismatches",
             results_seen, grants_seen, errors);
    if (errors == 0) $display("page_frame_bitmap_allocator_tb: PASS");
    else $display("page_frame_bitmap_allocator_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfba_pkg.sv
rtl/pfba_cmd_if.sv
rtl/pfba_rsp_if.sv
rtl/pfba_dp.sv
rtl/pfba_ctrl.sv
rtl/page_frame_bitmap_allocator.sv
test/page_frame_bitmap_allocator_tb.sv
